// ===== hdl/simon_pkg.sv =====
// simon_pkg: shared types, constants and round functions for the simon 128 core
package simon_pkg;

    // largest round count the key store holds by default
    localparam int MAX_ROUNDS_DEF = 72;

    // rounds per key size
    localparam int ROUNDS_128 = 68;
    localparam int ROUNDS_192 = 69;
    localparam int ROUNDS_256 = 72;

    // z-sequences repeat every 62 bits
    localparam int Z_PERIOD = 62;

    // key schedule constant 2^64 - 4
    localparam logic [63:0] KS_CONST = 64'hffff_ffff_ffff_fffc;

    localparam logic [63:0] Z2_SEQ = 64'h7369_f885_192c_0ef5;
    localparam logic [63:0] Z3_SEQ = 64'hfc2c_e512_07a6_35db;
    localparam logic [63:0] Z4_SEQ = 64'hfdc9_4c3a_046d_678b;

    // key size codes
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;
    localparam logic [1:0] KS_UNDEF = 2'd3;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_SIZE  = 3'd0,
        REG_KEY_WORD0 = 3'd1,
        REG_KEY_WORD1 = 3'd2,
        REG_KEY_WORD2 = 3'd3,
        REG_KEY_WORD3 = 3'd4
    } cfg_reg_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_block;   // capture a new block
        logic load_window;  // load the key schedule window from the key words
        logic exp_step;     // advance the key schedule by one word
        logic mem_we;       // write the oldest window word to the key store
        logic rd_en;        // read one round key
        logic round_en;     // apply one round
        logic dir;          // 0 encrypt, 1 decrypt
    } simon_cmd_t;

    // unused code maps to the 256-bit key
    function automatic logic [1:0] size_sel(input logic [1:0] ks);
        logic [1:0] sel;
        sel = (ks == KS_UNDEF) ? KS_256 : ks;
        return sel;
    endfunction

    function automatic logic [63:0] z_seq_of(input logic [1:0] sel);
        logic [63:0] z;
        case (sel)
            KS_128:  z = Z2_SEQ;
            KS_192:  z = Z3_SEQ;
            default: z = Z4_SEQ;
        endcase
        return z;
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
        logic [63:0] o;
        o = (v << r) | (v >> (64 - r));
        return o;
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] v, input int r);
        logic [63:0] o;
        o = (v >> r) | (v << (64 - r));
        return o;
    endfunction

    // feistel function f(x) = (x <<< 1 & x <<< 8) ^ x <<< 2
    function automatic logic [63:0] fround(input logic [63:0] x);
        logic [63:0] o;
        o = (rotl64(x, 1) & rotl64(x, 8)) ^ rotl64(x, 2);
        return o;
    endfunction

endpackage

// ===== hdl/simon_ctrl.sv =====
// simon_ctrl: sequencer for key expansion and the round loop
module simon_ctrl
    import simon_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF,
    parameter int ADDR_W     = $clog2(MAX_ROUNDS),
    parameter int CNT_W      = $clog2(MAX_ROUNDS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              func,
    input  logic              cfg_load,
    input  logic              cfg_we,
    input  logic [1:0]        key_size,
    output simon_cmd_t        cmd,
    output logic [ADDR_W-1:0] addr,
    output logic              busy,
    output logic              done
);

    // round counts clipped to the store depth
    localparam int R128 = (ROUNDS_128 > MAX_ROUNDS) ? MAX_ROUNDS : ROUNDS_128;
    localparam int R192 = (ROUNDS_192 > MAX_ROUNDS) ? MAX_ROUNDS : ROUNDS_192;
    localparam int R256 = (ROUNDS_256 > MAX_ROUNDS) ? MAX_ROUNDS : ROUNDS_256;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_EXPAND = 6'b000100,
        ST_FETCH  = 6'b001000,
        ST_ROUND  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             dir_reg, dir_next;
    logic [CNT_W-1:0] rounds;
    logic [CNT_W-1:0] idx_step;

    // round count of the current key size
    always_comb
    begin
        case (size_sel(key_size))
            KS_128:  rounds = CNT_W'(R128);
            KS_192:  rounds = CNT_W'(R192);
            default: rounds = CNT_W'(R256);
        endcase
    end

    // key address walks up for encryption, down for decryption
    assign idx_step = dir_reg ? (idx_reg - CNT_W'(1)) : (idx_reg + CNT_W'(1));

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        dir_next   = dir_reg;
        cmd        = '0;
        cmd.dir    = dir_reg;
        done       = 1'b0;
        if (cfg_load)
        begin
            state_next = ST_LOAD;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start && !cfg_we)
                    begin
                        cmd.load_block = 1'b1;
                        dir_next       = func;
                        rem_next       = rounds;
                        idx_next       = func ? (rounds - CNT_W'(1)) : '0;
                        state_next     = ST_FETCH;
                    end
                end
                ST_LOAD:
                begin
                    cmd.load_window = 1'b1;
                    idx_next        = '0;
                    state_next      = ST_EXPAND;
                end
                ST_EXPAND:
                begin
                    cmd.mem_we   = 1'b1;
                    cmd.exp_step = 1'b1;
                    if (idx_reg == CNT_W'(MAX_ROUNDS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                ST_FETCH:
                begin
                    cmd.rd_en  = 1'b1;
                    idx_next   = idx_step;
                    state_next = ST_ROUND;
                end
                ST_ROUND:
                begin
                    cmd.round_en = 1'b1;
                    rem_next     = rem_reg - CNT_W'(1);
                    if (rem_reg > CNT_W'(1))
                    begin
                        cmd.rd_en = 1'b1;
                        idx_next  = idx_step;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    assign addr = idx_reg[ADDR_W-1:0];
    assign busy = (state_reg != ST_IDLE) || cfg_we;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            rem_reg   <= '0;
            dir_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            dir_reg   <= dir_next;
        end
    end

endmodule

// ===== hdl/simon_dp.sv =====
// simon_dp: key schedule window, round key store and feistel round datapath
module simon_dp
    import simon_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF,
    parameter int ADDR_W     = $clog2(MAX_ROUNDS)
) (
    input  logic              clk,
    input  simon_cmd_t        cmd,
    input  logic [ADDR_W-1:0] addr,
    input  logic [1:0]        key_size,
    input  logic [63:0]       key_word0,
    input  logic [63:0]       key_word1,
    input  logic [63:0]       key_word2,
    input  logic [63:0]       key_word3,
    input  logic [63:0]       block_low,
    input  logic [63:0]       block_high,
    output logic [63:0]       result_low,
    output logic [63:0]       result_high
);

    logic [63:0] mem [MAX_ROUNDS];
    logic [63:0] w_reg [4];
    logic [63:0] rk_reg;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [1:0]  sel;
    logic [63:0] last_word;
    logic [63:0] new_word;
    logic [ADDR_W-1:0] z_full;
    logic [5:0]  z_idx;
    logic [63:0] z_word;
    logic        z_bit;

    assign sel = size_sel(key_size);

    // z index wraps at the sequence period
    assign z_full = (addr >= ADDR_W'(Z_PERIOD)) ? (addr - ADDR_W'(Z_PERIOD)) : addr;
    assign z_idx  = z_full[5:0];
    assign z_word = z_seq_of(sel);
    assign z_bit  = z_word[z_idx];

    // next schedule word from the window
    always_comb
    begin
        case (sel)
            KS_128:  last_word = w_reg[1];
            KS_192:  last_word = w_reg[2];
            default: last_word = w_reg[3];
        endcase
        new_word = w_reg[0] ^ KS_CONST ^ {63'd0, z_bit}
                 ^ rotr64(last_word, 3) ^ rotr64(last_word, 4);
        if (sel != KS_128 && sel != KS_192)
        begin
            new_word = new_word ^ w_reg[1] ^ rotr64(w_reg[1], 1);
        end
    end

    // schedule window shifts by one word per step
    always_ff @(posedge clk)
    begin
        if (cmd.load_window)
        begin
            w_reg[0] <= key_word0;
            w_reg[1] <= key_word1;
            w_reg[2] <= key_word2;
            w_reg[3] <= key_word3;
        end
        else if (cmd.exp_step)
        begin
            w_reg[0] <= w_reg[1];
            case (sel)
                KS_128:
                begin
                    w_reg[1] <= new_word;
                end
                KS_192:
                begin
                    w_reg[1] <= w_reg[2];
                    w_reg[2] <= new_word;
                end
                default:
                begin
                    w_reg[1] <= w_reg[2];
                    w_reg[2] <= w_reg[3];
                    w_reg[3] <= new_word;
                end
            endcase
        end
    end

    // round key store, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[addr] <= w_reg[0];
        end
        if (cmd.rd_en)
        begin
            rk_reg <= mem[addr];
        end
    end

    // feistel round, forward or inverse
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (cmd.load_block)
        begin
            x_next = block_high;
            y_next = block_low;
        end
        else if (cmd.round_en)
        begin
            if (cmd.dir)
            begin
                y_next = x_reg ^ fround(y_reg) ^ rk_reg;
                x_next = y_reg;
            end
            else
            begin
                x_next = y_reg ^ fround(x_reg) ^ rk_reg;
                y_next = x_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign result_low  = y_reg;
    assign result_high = x_reg;

endmodule

// ===== hdl/simon128_block_cipher_core.sv =====
// simon128_block_cipher_core: simon 128 block cipher top level with key registers
//
// channel   | ports                              | beat
// ----------+------------------------------------+------------------------------
// input     | start, busy, func, block_low/high  | start high while busy low
// result    | done, result_low, result_high      | done high for one cycle
// config    | cfg_we, cfg_addr, cfg_wdata        | cfg_we high, no wait
//
// a block runs from accept through a fetch state, the round states (68, 69 or
// 72 rounds) and a done state, at one feistel round per cycle and one key store
// read per round; a new block is accepted only after the previous one is done.
// every write to a known key register re-expands the key store, one store entry per
// cycle, with busy high until it ends. reset clears the key registers; the key
// store holds no data until the first write. results cannot be stalled.
module simon128_block_cipher_core
    import simon_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    output logic        done,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_ROUNDS);
    localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);

    logic [1:0]        key_size_reg;
    logic [63:0]       key_word_reg [4];
    logic              cfg_hit;
    simon_cmd_t        cmd;
    logic [ADDR_W-1:0] addr;

    // only writes to a known register restart the expansion
    assign cfg_hit = cfg_we && (cfg_addr inside {[REG_KEY_SIZE:REG_KEY_WORD3]});

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg    <= KS_128;
            key_word_reg[0] <= '0;
            key_word_reg[1] <= '0;
            key_word_reg[2] <= '0;
            key_word_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_KEY_SIZE:  key_size_reg    <= cfg_wdata[1:0];
                REG_KEY_WORD0: key_word_reg[0] <= cfg_wdata;
                REG_KEY_WORD1: key_word_reg[1] <= cfg_wdata;
                REG_KEY_WORD2: key_word_reg[2] <= cfg_wdata;
                REG_KEY_WORD3: key_word_reg[3] <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    simon_ctrl #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .func     (func),
        .cfg_load (cfg_hit),
        .cfg_we   (cfg_we),
        .key_size (key_size_reg),
        .cmd      (cmd),
        .addr     (addr),
        .busy     (busy),
        .done     (done)
    );

    simon_dp #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .ADDR_W     (ADDR_W)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .addr        (addr),
        .key_size    (key_size_reg),
        .key_word0   (key_word_reg[0]),
        .key_word1   (key_word_reg[1]),
        .key_word2   (key_word_reg[2]),
        .key_word3   (key_word_reg[3]),
        .block_low   (block_low),
        .block_high  (block_high),
        .result_low  (result_low),
        .result_high (result_high)
    );

    // an accepted block keeps the core busy on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cfg_we) |=> busy)
        else $error("core not busy after accepting a block");

    // a result only comes out of a running block
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy && $past(busy)))
        else $error("result strobe while idle");

    // the key store is never written and read in one cycle
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_we && cmd.rd_en))
        else $error("key store write and read collide");

    // rounds never run during key expansion
    a_round_expand: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.round_en && cmd.exp_step))
        else $error("round applied during key expansion");

endmodule
